>>> sv/cpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types, constants and saturating arithmetic for the closest-point
// pipeline.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int WIDE_W          = 64;
    localparam int HALF_W          = 32;
    localparam int MUL_LAT         = 4;
    localparam int USER_W          = 4;

    localparam logic [WIDE_W-1:0] MAG_NEG_LIM = {1'b1, {(WIDE_W-1){1'b0}}};
    localparam logic [WIDE_W-1:0] MAG_POS_LIM = {1'b0, {(WIDE_W-1){1'b1}}};

    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef enum logic [2:0] {
        REG_A    = 3'd0,
        REG_B    = 3'd1,
        REG_AB   = 3'd2,
        REG_C    = 3'd3,
        REG_AC   = 3'd4,
        REG_BC   = 3'd5,
        REG_FACE = 3'd6
    } region_t;

    typedef struct packed {
        logic    flag;
        region_t region;
    } tag_t;

    typedef struct packed {
        logic in_a;
        logic in_b;
        logic in_ab;
        logic in_c;
        logic in_ac;
        logic in_bc;
    } cond_t;

    function automatic wide_t sat_add(wide_t x, wide_t y);
        logic [WIDE_W:0] s;
        s = {x[WIDE_W-1], x} + {y[WIDE_W-1], y};
        if (s[WIDE_W] != s[WIDE_W-1])
            return s[WIDE_W] ? wide_t'(MAG_NEG_LIM) : wide_t'(MAG_POS_LIM);
        return wide_t'(s[WIDE_W-1:0]);
    endfunction

    function automatic wide_t sat_sub(wide_t x, wide_t y);
        logic [WIDE_W:0] s;
        s = {x[WIDE_W-1], x} - {y[WIDE_W-1], y};
        if (s[WIDE_W] != s[WIDE_W-1])
            return s[WIDE_W] ? wide_t'(MAG_NEG_LIM) : wide_t'(MAG_POS_LIM);
        return wide_t'(s[WIDE_W-1:0]);
    endfunction

    function automatic logic [WIDE_W-1:0] mag_of(wide_t x);
        return x[WIDE_W-1] ? (~x + 1'b1) : x;
    endfunction

    // signed result from sign and magnitude, clamped to the 64-bit range
    function automatic wide_t from_mag(logic neg, logic [WIDE_W-1:0] mag, logic over);
        logic [WIDE_W-1:0] lim;
        logic [WIDE_W-1:0] m;
        lim = neg ? MAG_NEG_LIM : MAG_POS_LIM;
        m   = (over || (mag > lim)) ? lim : mag;
        return neg ? wide_t'(~m + 1'b1) : wide_t'(m);
    endfunction

endpackage

>>> sv/cpt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_pipe
// Stallable delay line that keeps side data aligned with the arithmetic units.
// ----------------------------------------------------------------------------
module cpt_pipe #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign q = sr_reg[DEPTH-1];

endmodule

>>> sv/cpt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_mul
// Four-stage fixed point multiply: 64x64 exact product from 32x32 partials,
// shifted right by FRAC_BITS toward zero and saturated to 64 bits.
// ----------------------------------------------------------------------------
module cpt_mul #(
    parameter int FRAC_BITS = cpt_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          en,
    input  cpt_pkg::wide_t x,
    input  cpt_pkg::wide_t y,
    output cpt_pkg::wide_t p
);

    localparam int W  = cpt_pkg::WIDE_W;
    localparam int H  = cpt_pkg::HALF_W;
    localparam int FW = 2 * W;

    logic           neg1_reg, neg2_reg, neg3_reg;
    logic [W-1:0]   ma_reg, mb_reg;
    logic [W-1:0]   pp_reg [4];
    logic [FW-1:0]  full_reg;
    logic [FW-1:0]  full_next;
    cpt_pkg::wide_t p_reg;
    cpt_pkg::wide_t p_next;

    always_comb
    begin
        full_next = {{W{1'b0}}, pp_reg[0]}
                  + {{H{1'b0}}, pp_reg[1], {H{1'b0}}}
                  + {{H{1'b0}}, pp_reg[2], {H{1'b0}}}
                  + {pp_reg[3], {W{1'b0}}};
        p_next = cpt_pkg::from_mag(neg3_reg, full_reg[FRAC_BITS +: W],
                                   |full_reg[FW-1:W+FRAC_BITS]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg  <= x[W-1] ^ y[W-1];
            ma_reg    <= cpt_pkg::mag_of(x);
            mb_reg    <= cpt_pkg::mag_of(y);
            neg2_reg  <= neg1_reg;
            pp_reg[0] <= ma_reg[H-1:0] * mb_reg[H-1:0];
            pp_reg[1] <= ma_reg[H-1:0] * mb_reg[W-1:H];
            pp_reg[2] <= ma_reg[W-1:H] * mb_reg[H-1:0];
            pp_reg[3] <= ma_reg[W-1:H] * mb_reg[W-1:H];
            neg3_reg  <= neg2_reg;
            full_reg  <= full_next;
            p_reg     <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> sv/cpt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined restoring divider: num * 2^FRAC_BITS / den, one quotient bit per
// stage, truncated toward zero, saturated; zero denominator gives zero.
// ----------------------------------------------------------------------------
module cpt_div #(
    parameter int FRAC_BITS = cpt_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          en,
    input  cpt_pkg::wide_t num,
    input  cpt_pkg::wide_t den,
    output cpt_pkg::wide_t q
);

    localparam int W  = cpt_pkg::WIDE_W;
    localparam int QB = W + FRAC_BITS;

    logic [W-1:0]   r_reg  [QB+1];
    logic [W-1:0]   d_reg  [QB+1];
    logic [QB-1:0]  nq_reg [QB+1];
    logic [QB:0]    neg_reg;
    logic [QB:0]    zero_reg;
    cpt_pkg::wide_t q_reg;
    cpt_pkg::wide_t q_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= '0;
            d_reg[0]    <= cpt_pkg::mag_of(den);
            nq_reg[0]   <= {cpt_pkg::mag_of(num), {FRAC_BITS{1'b0}}};
            neg_reg[0]  <= num[W-1] ^ den[W-1];
            zero_reg[0] <= (den == '0);
        end
    end

    genvar gs;
    generate
        for (gs = 1; gs <= QB; gs++)
        begin : g_step
            logic [W:0]    rs;
            logic          ge;
            logic [W-1:0]  r_next;
            logic [QB-1:0] nq_next;

            always_comb
            begin
                rs      = {r_reg[gs-1], nq_reg[gs-1][QB-1]};
                ge      = (rs >= {1'b0, d_reg[gs-1]});
                r_next  = ge ? W'(rs - {1'b0, d_reg[gs-1]}) : rs[W-1:0];
                nq_next = {nq_reg[gs-1][QB-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[gs]    <= r_next;
                    d_reg[gs]    <= d_reg[gs-1];
                    nq_reg[gs]   <= nq_next;
                    neg_reg[gs]  <= neg_reg[gs-1];
                    zero_reg[gs] <= zero_reg[gs-1];
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (zero_reg[QB])
            q_next = '0;
        else
            q_next = cpt_pkg::from_mag(neg_reg[QB], nq_reg[QB][W-1:0],
                                       |nq_reg[QB][QB-1:W]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

>>> sv/closest_point_on_triangle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_on_triangle
// Nearest point of a triangle to a query point, with the winning region code,
// in a fully pipelined fixed point datapath.
// ----------------------------------------------------------------------------
//  channel   | signals                 | contents
//  ----------+-------------------------+--------------------------------------
//  query in  | s_axis_tvalid/tready    | tdata: point, vertex a, b, c (x,y,z)
//  result    | m_axis_tvalid/tready    | tdata: closest x,y,z; tuser: region,
//            |                         | degenerate flag
//
//  One request per cycle while the result is not stalled; most of the latency
//  is the two bit-per-stage dividers for the edge and face weights.
//  Reset clears only the stage valid bits; no warm-up is needed.
//  The whole pipe advances whenever the output stage is empty or being taken;
//  a stalled result holds and s_axis_tready drops with it.
// ----------------------------------------------------------------------------
module closest_point_on_triangle #(
    parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = cpt_pkg::FRAC_BITS_DEF,
    localparam int IN_TW      = ((12 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW     = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // point x,y,z, vert_a x,y,z, vert_b x,y,z, vert_c x,y,z
    input  logic [IN_TW-1:0]           s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // closest_x, closest_y, closest_z
    output logic [OUT_TW-1:0]          m_axis_tdata,
    // region_code[2:0], degenerate_flag[3]
    output logic [cpt_pkg::USER_W-1:0] m_axis_tuser
);

    localparam int W       = cpt_pkg::WIDE_W;
    localparam int CW      = COORD_WIDTH;
    localparam int ML      = cpt_pkg::MUL_LAT;
    localparam int DIV_LAT = W + FRAC_BITS + 2;
    localparam int LAT     = 22 + DIV_LAT;
    localparam int VTX_DLY = 13 + DIV_LAT;
    localparam int TW      = $bits(cpt_pkg::tag_t);

    localparam int unsigned MX [6] = '{0, 2, 4, 0, 2, 4};
    localparam int unsigned MY [6] = '{3, 1, 1, 5, 5, 3};

    localparam cpt_pkg::wide_t CRD_MAX = cpt_pkg::wide_t'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam cpt_pkg::wide_t CRD_MIN = -CRD_MAX - 64'sd1;

    function automatic cpt_pkg::wide_t ext(logic [CW-1:0] v);
        return cpt_pkg::wide_t'($signed(v));
    endfunction

    logic             en;
    logic [LAT-1:0]   vld_reg;
    logic [LAT-1:0]   vld_next;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign vld_next      = {vld_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // stage 1: differences
    logic [11:0][CW-1:0]           crd;
    cpt_pkg::wide_t [1:0][2:0]     edge_reg, edge_next;
    cpt_pkg::wide_t [2:0][2:0]     vec_reg, vec_next;
    logic [8:0][CW-1:0]            vtx_reg;

    always_comb
    begin
        for (int k = 0; k < 12; k++)
        begin
            crd[k] = s_axis_tdata[k*CW +: CW];
        end
        for (int k = 0; k < 3; k++)
        begin
            edge_next[0][k] = ext(crd[6+k]) - ext(crd[3+k]);
            edge_next[1][k] = ext(crd[9+k]) - ext(crd[3+k]);
            vec_next[0][k]  = ext(crd[k]) - ext(crd[3+k]);
            vec_next[1][k]  = ext(crd[k]) - ext(crd[6+k]);
            vec_next[2][k]  = ext(crd[k]) - ext(crd[9+k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            edge_reg <= edge_next;
            vec_reg  <= vec_next;
            vtx_reg  <= crd[11:3];
        end
    end

    // dot product terms, d1..d6 at index 0..5
    cpt_pkg::wide_t [5:0][2:0] dprod;

    genvar gi, ge, gk;
    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_dv
            for (ge = 0; ge < 2; ge++)
            begin : g_de
                for (gk = 0; gk < 3; gk++)
                begin : g_dk
                    cpt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
                        .clk (clk),
                        .en  (en),
                        .x   (edge_reg[ge][gk]),
                        .y   (vec_reg[gi][gk]),
                        .p   (dprod[gi*2+ge][gk])
                    );
                end
            end
        end
    endgenerate

    cpt_pkg::wide_t [5:0] dsum_reg, dsum_next, dlast_reg, dot_reg, dot_next;

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            dsum_next[j] = cpt_pkg::sat_add(dprod[j][0], dprod[j][1]);
            dot_next[j]  = cpt_pkg::sat_add(dsum_reg[j], dlast_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsum_reg <= dsum_next;
            for (int j = 0; j < 6; j++)
            begin
                dlast_reg[j] <= dprod[j][2];
            end
            dot_reg <= dot_next;
        end
    end

    // barycentric numerator products
    cpt_pkg::wide_t [5:0] vprod;
    cpt_pkg::wide_t [5:0] dot_dly;

    generate
        for (gi = 0; gi < 6; gi++)
        begin : g_vp
            cpt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
                .clk (clk),
                .en  (en),
                .x   (dot_reg[MX[gi]]),
                .y   (dot_reg[MY[gi]]),
                .p   (vprod[gi])
            );
        end
    endgenerate

    cpt_pipe #(.W(6 * W), .DEPTH(ML)) u_dot_dly (
        .clk (clk),
        .en  (en),
        .d   (dot_reg),
        .q   (dot_dly)
    );

    cpt_pkg::wide_t       va_reg, vb_reg, vc_reg, e1_reg, e2_reg;
    cpt_pkg::wide_t       va_next, vb_next, vc_next, e1_next, e2_next;
    cpt_pkg::wide_t [5:0] dotv_reg;

    always_comb
    begin
        vc_next = cpt_pkg::sat_sub(vprod[0], vprod[1]);
        vb_next = cpt_pkg::sat_sub(vprod[2], vprod[3]);
        va_next = cpt_pkg::sat_sub(vprod[4], vprod[5]);
        e1_next = cpt_pkg::sat_sub(dot_dly[3], dot_dly[2]);
        e2_next = cpt_pkg::sat_sub(dot_dly[4], dot_dly[5]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            va_reg   <= va_next;
            vb_reg   <= vb_next;
            vc_reg   <= vc_next;
            e1_reg   <= e1_next;
            e2_reg   <= e2_next;
            dotv_reg <= dot_dly;
        end
    end

    // region tests and denominators
    cpt_pkg::cond_t cond_reg, cond_next;
    cpt_pkg::wide_t den_ab_reg, den_ac_reg, den_bc_reg, sum1_reg;
    cpt_pkg::wide_t den_ab_next, den_ac_next, den_bc_next, sum1_next;
    cpt_pkg::wide_t vc2_reg, vb2_reg, d1_reg, d2_reg, e1b_reg;

    always_comb
    begin
        cond_next.in_a  = (dotv_reg[0] <= 0) && (dotv_reg[1] <= 0);
        cond_next.in_b  = (dotv_reg[2] >= 0) && (dotv_reg[3] <= dotv_reg[2]);
        cond_next.in_ab = (vc_reg <= 0) && (dotv_reg[0] >= 0) && (dotv_reg[2] <= 0);
        cond_next.in_c  = (dotv_reg[5] >= 0) && (dotv_reg[4] <= dotv_reg[5]);
        cond_next.in_ac = (vb_reg <= 0) && (dotv_reg[1] >= 0) && (dotv_reg[5] <= 0);
        cond_next.in_bc = (va_reg <= 0) && (e1_reg >= 0) && (e2_reg >= 0);
        den_ab_next     = cpt_pkg::sat_sub(dotv_reg[0], dotv_reg[2]);
        den_ac_next     = cpt_pkg::sat_sub(dotv_reg[1], dotv_reg[5]);
        den_bc_next     = cpt_pkg::sat_add(e1_reg, e2_reg);
        sum1_next       = cpt_pkg::sat_add(va_reg, vb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cond_reg   <= cond_next;
            den_ab_reg <= den_ab_next;
            den_ac_reg <= den_ac_next;
            den_bc_reg <= den_bc_next;
            sum1_reg   <= sum1_next;
            vc2_reg    <= vc_reg;
            vb2_reg    <= vb_reg;
            d1_reg     <= dotv_reg[0];
            d2_reg     <= dotv_reg[1];
            e1b_reg    <= e1_reg;
        end
    end

    // region select and divider operands
    cpt_pkg::wide_t sum_comb;
    cpt_pkg::wide_t numa_reg, dena_reg, numb_reg, denb_reg;
    cpt_pkg::wide_t numa_next, dena_next, numb_next, denb_next;
    cpt_pkg::tag_t  tag_reg, tag_next;

    always_comb
    begin
        sum_comb        = cpt_pkg::sat_add(sum1_reg, vc2_reg);
        numa_next       = '0;
        dena_next       = '0;
        numb_next       = '0;
        denb_next       = '0;
        tag_next.flag   = 1'b0;
        tag_next.region = cpt_pkg::REG_A;
        priority if (cond_reg.in_a)
        begin
            tag_next.region = cpt_pkg::REG_A;
        end
        else if (cond_reg.in_b)
        begin
            tag_next.region = cpt_pkg::REG_B;
        end
        else if (cond_reg.in_ab)
        begin
            tag_next.region = cpt_pkg::REG_AB;
            numa_next       = d1_reg;
            dena_next       = den_ab_reg;
        end
        else if (cond_reg.in_c)
        begin
            tag_next.region = cpt_pkg::REG_C;
        end
        else if (cond_reg.in_ac)
        begin
            tag_next.region = cpt_pkg::REG_AC;
            numa_next       = d2_reg;
            dena_next       = den_ac_reg;
        end
        else if (cond_reg.in_bc)
        begin
            tag_next.region = cpt_pkg::REG_BC;
            numa_next       = e1b_reg;
            dena_next       = den_bc_reg;
        end
        else if (sum_comb == '0)
        begin
            // degenerate face: fall back to vertex a
            tag_next.region = cpt_pkg::REG_A;
            tag_next.flag   = 1'b1;
        end
        else
        begin
            tag_next.region = cpt_pkg::REG_FACE;
            numa_next       = vb2_reg;
            dena_next       = sum_comb;
            numb_next       = vc2_reg;
            denb_next       = sum_comb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numa_reg <= numa_next;
            dena_reg <= dena_next;
            numb_reg <= numb_next;
            denb_reg <= denb_next;
            tag_reg  <= tag_next;
        end
    end

    cpt_pkg::wide_t     qa, qb;
    cpt_pkg::tag_t      tag_dly;
    logic [8:0][CW-1:0] vtx_dly;

    cpt_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
        .clk (clk),
        .en  (en),
        .num (numa_reg),
        .den (dena_reg),
        .q   (qa)
    );

    cpt_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
        .clk (clk),
        .en  (en),
        .num (numb_reg),
        .den (denb_reg),
        .q   (qb)
    );

    cpt_pipe #(.W(TW), .DEPTH(DIV_LAT)) u_tag_dly (
        .clk (clk),
        .en  (en),
        .d   (tag_reg),
        .q   (tag_dly)
    );

    cpt_pipe #(.W(9 * CW), .DEPTH(VTX_DLY)) u_vtx_dly (
        .clk (clk),
        .en  (en),
        .d   (vtx_reg),
        .q   (vtx_dly)
    );

    // point assembly: base + edge_a * qa + edge_b * qb
    cpt_pkg::wide_t [2:0] base_reg, base_next, ea_reg, ea_next, eb_reg, eb_next;
    cpt_pkg::wide_t       qa_reg, qb_reg;
    cpt_pkg::tag_t        tagf_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            eb_next[k]   = ext(vtx_dly[6+k]) - ext(vtx_dly[k]);
            ea_next[k]   = '0;
            base_next[k] = ext(vtx_dly[k]);
            unique case (tag_dly.region)
                cpt_pkg::REG_A: base_next[k] = ext(vtx_dly[k]);
                cpt_pkg::REG_B: base_next[k] = ext(vtx_dly[3+k]);
                cpt_pkg::REG_C: base_next[k] = ext(vtx_dly[6+k]);
                cpt_pkg::REG_AB,
                cpt_pkg::REG_FACE: ea_next[k] = ext(vtx_dly[3+k]) - ext(vtx_dly[k]);
                cpt_pkg::REG_AC: ea_next[k] = ext(vtx_dly[6+k]) - ext(vtx_dly[k]);
                cpt_pkg::REG_BC:
                begin
                    base_next[k] = ext(vtx_dly[3+k]);
                    ea_next[k]   = ext(vtx_dly[6+k]) - ext(vtx_dly[3+k]);
                end
                default: base_next[k] = ext(vtx_dly[k]);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg <= base_next;
            ea_reg   <= ea_next;
            eb_reg   <= eb_next;
            qa_reg   <= qa;
            qb_reg   <= qb;
            tagf_reg <= tag_dly;
        end
    end

    cpt_pkg::wide_t [2:0] fa, fb, base_dly;
    cpt_pkg::tag_t        tagm_dly;

    generate
        for (gk = 0; gk < 3; gk++)
        begin : g_pt
            cpt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (
                .clk (clk),
                .en  (en),
                .x   (ea_reg[gk]),
                .y   (qa_reg),
                .p   (fa[gk])
            );

            cpt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_b (
                .clk (clk),
                .en  (en),
                .x   (eb_reg[gk]),
                .y   (qb_reg),
                .p   (fb[gk])
            );
        end
    endgenerate

    cpt_pipe #(.W(3 * W + TW), .DEPTH(ML)) u_base_dly (
        .clk (clk),
        .en  (en),
        .d   ({tagf_reg, base_reg}),
        .q   ({tagm_dly, base_dly})
    );

    cpt_pkg::wide_t [2:0] t_reg, t_next, fb_reg, pt_reg, pt_next;
    cpt_pkg::tag_t        tag1_reg, tag2_reg, tag3_reg;
    logic [2:0][CW-1:0]   out_reg, out_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t_next[k]  = cpt_pkg::sat_add(base_dly[k], fa[k]);
            pt_next[k] = cpt_pkg::sat_add(t_reg[k], fb_reg[k]);
            if (pt_reg[k] > CRD_MAX)
                out_next[k] = CRD_MAX[CW-1:0];
            else if (pt_reg[k] < CRD_MIN)
                out_next[k] = CRD_MIN[CW-1:0];
            else
                out_next[k] = pt_reg[k][CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg    <= t_next;
            fb_reg   <= fb;
            tag1_reg <= tagm_dly;
            pt_reg   <= pt_next;
            tag2_reg <= tag1_reg;
            out_reg  <= out_next;
            tag3_reg <= tag2_reg;
        end
    end

    assign m_axis_tdata = OUT_TW'(out_reg);
    assign m_axis_tuser = tag3_reg;

endmodule

>>> sv/cpt_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpt_check
// Port-level checks for the closest-point pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module cpt_check #(
    parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF,
    localparam int IN_TW      = ((12 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW     = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [IN_TW-1:0]           s_axis_tdata,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [OUT_TW-1:0]          m_axis_tdata,
    input logic [cpt_pkg::USER_W-1:0] m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata))
        else $error("pending request withdrawn or changed");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] == cpt_pkg::REG_A)
        else $error("degenerate result not tagged as vertex a");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while pipe is stalled");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pipe not accepting with empty output");

endmodule

bind closest_point_on_triangle cpt_check #(.COORD_WIDTH(COORD_WIDTH)) u_cpt_check (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams closest-point queries through closest_point_on_triangle under
// random source bursts and sink stalls, predicts each nearest point, region
// and degenerate flag in fixed point, and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CW    = 32;
    localparam int FB    = 16;
    localparam int IN_W  = 12 * CW;
    localparam int OUT_W = 3 * CW;
    localparam int LAT   = FB + 88;
    localparam int N_RND = 1200;
    localparam longint CYCLE_LIMIT = 400000;

    typedef cpt_pkg::wide_t       wide_t;
    typedef cpt_pkg::region_t     region_t;
    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t  x, y, z;
        region_t region;
        logic    flag;
    } nearest_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [cpt_pkg::USER_W-1:0] m_axis_tuser;

    logic [IN_W-1:0] query_queue[$];
    nearest_t        nearest_queue[$];
    int              err_count;
    longint          cycle_count;
    bit              stim_done;
    bit              in_taken;
    int              burst_left;
    int              gap_left;
    int              stall_phase;

    closest_point_on_triangle dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // exact product, truncated toward zero, shifted by FB, saturated
    function automatic wide_t fx_mul(wide_t x, wide_t y);
        logic               neg;
        logic [127:0]       p;
        logic [127:0]       m;
        neg = (x < 0) != (y < 0);
        p = 128'(cpt_pkg::mag_of(x)) * 128'(cpt_pkg::mag_of(y));
        m = p >> FB;
        return cpt_pkg::from_mag(neg, m[63:0], m[127:64] != 0);
    endfunction

    function automatic wide_t fx_div(wide_t num, wide_t den);
        logic [127:0] n;
        logic [127:0] q;
        if (den == 0)
            return 0;
        n = 128'(cpt_pkg::mag_of(num)) << FB;
        q = n / 128'(cpt_pkg::mag_of(den));
        return cpt_pkg::from_mag((num < 0) != (den < 0), q[63:0], q[127:64] != 0);
    endfunction

    function automatic wide_t dot(wide_t u[3], wide_t v[3]);
        wide_t s;
        s = fx_mul(u[0], v[0]);
        s = cpt_pkg::sat_add(s, fx_mul(u[1], v[1]));
        return cpt_pkg::sat_add(s, fx_mul(u[2], v[2]));
    endfunction

    function automatic coord_t clamp(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        lo = -(64'sd1 <<< (CW - 1));
        if (v > hi)
            return coord_t'(hi);
        if (v < lo)
            return coord_t'(lo);
        return coord_t'(v);
    endfunction

    function automatic nearest_t nearest_point(logic [IN_W-1:0] q);
        wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
        wide_t pt[3];
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, v, w, sum, e1, e2;
        nearest_t r;
        r.flag = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            p[k] = wide_t'(coord_t'(q[k*CW +: CW]));
            a[k] = wide_t'(coord_t'(q[(3+k)*CW +: CW]));
            b[k] = wide_t'(coord_t'(q[(6+k)*CW +: CW]));
            c[k] = wide_t'(coord_t'(q[(9+k)*CW +: CW]));
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
            bc[k] = c[k] - b[k];
        end
        d1 = dot(ab, ap);
        d2 = dot(ac, ap);
        d3 = dot(ab, bp);
        d4 = dot(ac, bp);
        d5 = dot(ab, cp);
        d6 = dot(ac, cp);
        vc = cpt_pkg::sat_sub(fx_mul(d1, d4), fx_mul(d3, d2));
        vb = cpt_pkg::sat_sub(fx_mul(d5, d2), fx_mul(d1, d6));
        va = cpt_pkg::sat_sub(fx_mul(d3, d6), fx_mul(d5, d4));
        e1 = cpt_pkg::sat_sub(d4, d3);
        e2 = cpt_pkg::sat_sub(d5, d6);
        if (d1 <= 0 && d2 <= 0)
        begin
            r.region = cpt_pkg::REG_A;
            pt = a;
        end
        else if (d3 >= 0 && d4 <= d3)
        begin
            r.region = cpt_pkg::REG_B;
            pt = b;
        end
        else if (vc <= 0 && d1 >= 0 && d3 <= 0)
        begin
            r.region = cpt_pkg::REG_AB;
            v = fx_div(d1, cpt_pkg::sat_sub(d1, d3));
            for (int k = 0; k < 3; k++)
                pt[k] = cpt_pkg::sat_add(a[k], fx_mul(ab[k], v));
        end
        else if (d6 >= 0 && d5 <= d6)
        begin
            r.region = cpt_pkg::REG_C;
            pt = c;
        end
        else if (vb <= 0 && d2 >= 0 && d6 <= 0)
        begin
            r.region = cpt_pkg::REG_AC;
            w = fx_div(d2, cpt_pkg::sat_sub(d2, d6));
            for (int k = 0; k < 3; k++)
                pt[k] = cpt_pkg::sat_add(a[k], fx_mul(ac[k], w));
        end
        else if (va <= 0 && e1 >= 0 && e2 >= 0)
        begin
            r.region = cpt_pkg::REG_BC;
            w = fx_div(e1, cpt_pkg::sat_add(e1, e2));
            for (int k = 0; k < 3; k++)
                pt[k] = cpt_pkg::sat_add(b[k], fx_mul(bc[k], w));
        end
        else
        begin
            sum = cpt_pkg::sat_add(cpt_pkg::sat_add(va, vb), vc);
            if (sum == 0)
            begin
                r.region = cpt_pkg::REG_A;
                r.flag = 1'b1;
                pt = a;
            end
            else
            begin
                r.region = cpt_pkg::REG_FACE;
                v = fx_div(vb, sum);
                w = fx_div(vc, sum);
                for (int k = 0; k < 3; k++)
                    pt[k] = cpt_pkg::sat_add(cpt_pkg::sat_add(a[k], fx_mul(ab[k], v)),
                                             fx_mul(ac[k], w));
            end
        end
        r.x = clamp(pt[0]);
        r.y = clamp(pt[1]);
        r.z = clamp(pt[2]);
        return r;
    endfunction

    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 32'h000F_FFFF)) - coord_t'(32'h0008_0000);
            2: return coord_t'($urandom_range(0, 32'h0000_3FFF)) - coord_t'(32'h0000_2000);
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return coord_t'(32'h7FFF_FFFF);
                    1: return coord_t'(32'h8000_0000);
                    2: return '0;
                    default: return coord_t'(32'h0001_0000);
                endcase
            end
        endcase
    endfunction

    task automatic push_query(coord_t v[12]);
        logic [IN_W-1:0] q;
        for (int k = 0; k < 12; k++)
            q[k*CW +: CW] = v[k];
        query_queue.push_back(q);
    endtask

    function automatic coord_t fx(int n);
        return coord_t'(n * 65536);
    endfunction

    task automatic push_tri(int px, int py, int pz, int ax, int ay, int az,
                            int bx, int by, int bz, int cx, int cy, int cz);
        coord_t v[12];
        v = '{fx(px), fx(py), fx(pz), fx(ax), fx(ay), fx(az),
              fx(bx), fx(by), fx(bz), fx(cx), fx(cy), fx(cz)};
        push_query(v);
    endtask

    initial
    begin
        coord_t v[12];
        int mode;
        // triangle a(0,0,0) b(4,0,0) c(0,4,0): each region in turn
        push_tri(-1, -1, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0);
        push_tri(5, -1, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0);
        push_tri(2, -3, 1, 0, 0, 0, 4, 0, 0, 0, 4, 0);
        push_tri(-1, 5, 0, 0, 0, 0, 4, 0, 0, 0, 4, 0);
        push_tri(-3, 2, 1, 0, 0, 0, 4, 0, 0, 0, 4, 0);
        push_tri(3, 3, 2, 0, 0, 0, 4, 0, 0, 0, 4, 0);
        push_tri(1, 1, 5, 0, 0, 0, 4, 0, 0, 0, 4, 0);
        // degenerate: collinear and all-equal vertices
        push_tri(1, 1, 1, 0, 0, 0, 1, 1, 1, 2, 2, 2);
        push_tri(1, 2, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_tri(3, 3, 3, 1, 1, 1, 1, 1, 1, 2, 2, 2);
        // zero-length edges
        push_tri(1, -2, 0, 0, 0, 0, 0, 0, 0, 0, 4, 0);
        push_tri(-2, 1, 0, 0, 0, 0, 4, 0, 0, 4, 0, 0);
        // field extremes, saturation
        for (int k = 0; k < 12; k++) v[k] = coord_t'(32'h7FFF_FFFF);
        push_query(v);
        for (int k = 0; k < 12; k++) v[k] = coord_t'(32'h8000_0000);
        push_query(v);
        for (int k = 0; k < 12; k++) v[k] = (k % 2) ? coord_t'(32'h8000_0000) : coord_t'(32'h7FFF_FFFF);
        push_query(v);
        for (int k = 0; k < 12; k++) v[k] = (k % 3 == 0) ? coord_t'(32'h8000_0000) : coord_t'(32'h7FFF_FFFF);
        push_query(v);
        for (int k = 0; k < 12; k++) v[k] = '0;
        push_query(v);
        for (int k = 0; k < 12; k++) v[k] = coord_t'(32'hFFFF_FFFF);
        push_query(v);
        for (int n = 0; n < N_RND; n++)
        begin
            mode = $urandom_range(0, 9);
            for (int k = 0; k < 12; k++)
                v[k] = rnd_coord(mode < 3 ? 0 : mode < 6 ? 1 : mode < 9 ? 2 : 3);
            push_query(v);
        end
        stim_done = 1'b1;
    end

    initial
    begin
        err_count = 0;
        cycle_count = 0;
        in_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // source: bursts with random gaps; a pending request holds until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                void'(query_queue.pop_front());
            if (s_axis_tvalid && !in_taken)
            begin
                s_axis_tvalid <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (query_queue.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= query_queue[0];
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // sink: stalls follow a slowly drifting pattern
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 256) % 4)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= (stall_phase % 7) < 3;
                default: m_axis_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        nearest_t exp_r;
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                nearest_queue.push_back(nearest_point(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (nearest_queue.size() == 0)
                begin
                    $error("result with no request pending");
                    err_count++;
                end
                else
                begin
                    exp_r = nearest_queue.pop_front();
                    if (m_axis_tdata[0 +: CW] !== exp_r.x)
                    begin
                        $error("closest_x exp %h got %h", exp_r.x, m_axis_tdata[0 +: CW]);
                        err_count++;
                    end
                    if (m_axis_tdata[CW +: CW] !== exp_r.y)
                    begin
                        $error("closest_y exp %h got %h", exp_r.y, m_axis_tdata[CW +: CW]);
                        err_count++;
                    end
                    if (m_axis_tdata[2*CW +: CW] !== exp_r.z)
                    begin
                        $error("closest_z exp %h got %h", exp_r.z, m_axis_tdata[2*CW +: CW]);
                        err_count++;
                    end
                    if (m_axis_tuser[2:0] !== exp_r.region)
                    begin
                        $error("region_code exp %0d got %0d", exp_r.region, m_axis_tuser[2:0]);
                        err_count++;
                    end
                    if (m_axis_tuser[3] !== exp_r.flag)
                    begin
                        $error("degenerate_flag exp %0d got %0d", exp_r.flag, m_axis_tuser[3]);
                        err_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        wait (stim_done && query_queue.size() == 0 && !s_axis_tvalid
              && nearest_queue.size() == 0);
        repeat (2 * LAT) @(posedge clk);
        if (err_count == 0 && nearest_queue.size() == 0)
            $display("[closest_point_on_triangle] OK");
        else
            $display("[closest_point_on_triangle] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[closest_point_on_triangle] ERROR");
            $finish;
        end
    end

endmodule

>>> sim.f
sv/cpt_pkg.sv
sv/cpt_pipe.sv
sv/cpt_mul.sv
sv/cpt_div.sv
sv/closest_point_on_triangle.sv
sv/cpt_check.sv
tb/testbench.sv
